@@ rtl/pwlt_pkg.sv @@
// Package for the piecewise linear interpolation table.
// Holds table sizes, command and status codes, state type and controller/datapath bundles.
package pwlt_pkg;
   localparam int TableRows = 256;
   localparam int RowBits   = $clog2(TableRows);
   localparam int CountBits = RowBits + 1;
   localparam int NumCols   = 6;
   localparam int ColBits   = 3;
   localparam int DataBits  = 32;

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_QUERY = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [2:0] ST_INTERP = 3'd0;
   localparam logic [2:0] ST_LOW    = 3'd1;
   localparam logic [2:0] ST_HIGH   = 3'd2;
   localparam logic [2:0] ST_EMPTY  = 3'd3;
   localparam logic [2:0] ST_FULL   = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   typedef enum logic [3:0] {
      S_IDLE, S_RD_FIRST, S_CHK_FIRST, S_RD_LAST, S_CHK_LAST,
      S_SCAN_RD, S_SCAN_CHK, S_RD_LO, S_MUL, S_DIV_LOAD, S_DIV, S_FIN, S_OUT
   } state_type;

   typedef struct packed {
      logic                 capture;    // latch the request
      logic                 write_row;  // append the captured row
      logic                 clear_rows;
      logic                 rd_en;
      logic [RowBits-1:0]   rd_addr;
      logic                 take_hi;    // store read data as the upper row
      logic                 take_lo;    // store read data as the lower row
      logic                 mul_go;
      logic                 div_start;
      logic                 div_step;
      logic                 set_result; // load result register
      logic                 res_from_hi; // clamp: value of read row
      logic [2:0]           res_status;
      logic                 res_zero;
   } cmd_type;

   typedef struct packed {
      logic [1:0]           command;
      logic [CountBits-1:0] rows;
      logic                 e_le_rd;   // query energy <= energy read
      logic                 e_ge_rd;
      logic                 div_done;
   } stat_type;
endpackage

@@ rtl/pwlt_datapath.sv @@
// Datapath: row memories, query registers, multiplier and restoring divider.
// Depends on pwlt_pkg.
module pwlt_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [1:0]                    req_command,
   input  logic [2:0]                    req_query_quantity,
   input  logic [31:0]                   req_row_energy,
   input  logic [pwlt_pkg::NumCols*32-1:0] req_row_cols,
   input  pwlt_pkg::cmd_type             cmd,
   output pwlt_pkg::stat_type            stat,
   output logic [31:0]                   result_value,
   output logic [2:0]                    result_status
);
   import pwlt_pkg::*;

   logic [31:0] energy_mem [TableRows];
   logic [NumCols*32-1:0] col_mem [TableRows];

   logic [1:0]  command_ff;
   logic [2:0]  col_ff;
   logic [31:0] energy_ff;
   logic [NumCols*32-1:0] row_ff;
   logic [CountBits-1:0] rows_ff;
   logic [31:0] rd_e_ff;
   logic [NumCols*32-1:0] rd_row_ff;
   logic [31:0] e_hi_ff, v_hi_ff, e_lo_ff, v_lo_ff;
   logic [63:0] prod_ff;
   logic [31:0] wid_ff;
   logic [63:0] quo_ff;
   logic [32:0] rem_ff;
   logic [6:0]  cnt_ff;
   logic [31:0] res_ff;
   logic [2:0]  status_ff;
   logic [2:0]  col_sel;
   logic [31:0] rd_val;
   logic        up;
   logic [31:0] mag;
   logic [32:0] rem_sh;

   assign col_sel = (col_ff >= 3'(NumCols)) ? 3'(NumCols - 1) : col_ff;
   assign rd_val  = rd_row_ff[col_sel*32 +: 32];
   assign up      = v_hi_ff >= v_lo_ff;
   assign mag     = up ? (v_hi_ff - v_lo_ff) : (v_lo_ff - v_hi_ff);
   assign rem_sh  = {rem_ff[31:0], quo_ff[63]};

   always_ff @(posedge clock) begin
      if (cmd.write_row && rows_ff < CountBits'(TableRows)) begin
         energy_mem[rows_ff[RowBits-1:0]] <= energy_ff;
         col_mem[rows_ff[RowBits-1:0]]    <= row_ff;
      end
      if (cmd.rd_en) begin
         rd_e_ff   <= energy_mem[cmd.rd_addr];
         rd_row_ff <= col_mem[cmd.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= '0;
      end else if (cmd.clear_rows) begin
         rows_ff <= '0;
      end else if (cmd.write_row && rows_ff < CountBits'(TableRows)) begin
         rows_ff <= rows_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         command_ff <= req_command;
         col_ff     <= req_query_quantity;
         energy_ff  <= req_row_energy;
         row_ff     <= req_row_cols;
      end
      if (cmd.take_hi) begin
         e_hi_ff <= rd_e_ff;
         v_hi_ff <= rd_val;
      end
      if (cmd.take_lo) begin
         e_lo_ff <= rd_e_ff;
         v_lo_ff <= rd_val;
      end
      if (cmd.mul_go) begin
         prod_ff <= 64'(mag) * 64'(energy_ff - e_lo_ff);
         wid_ff  <= e_hi_ff - e_lo_ff;
      end
      // Restoring division, one quotient bit per cycle.
      if (cmd.div_start) begin
         quo_ff <= prod_ff;
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         if (rem_sh >= {1'b0, wid_ff}) begin
            rem_ff <= rem_sh - {1'b0, wid_ff};
            quo_ff <= {quo_ff[62:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[62:0], 1'b0};
         end
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.set_result) begin
         status_ff <= cmd.res_status;
         if (cmd.res_zero) begin
            res_ff <= '0;
         end else if (cmd.res_from_hi) begin
            res_ff <= rd_val;
         end else if (up) begin
            res_ff <= v_lo_ff + quo_ff[31:0];
         end else begin
            res_ff <= v_lo_ff - quo_ff[31:0];
         end
      end
   end

   assign stat.command  = command_ff;
   assign stat.rows     = rows_ff;
   assign stat.e_le_rd  = energy_ff <= rd_e_ff;
   assign stat.e_ge_rd  = energy_ff >= rd_e_ff;
   assign stat.div_done = cnt_ff == 7'd64;
   assign result_value  = res_ff;
   assign result_status = status_ff;
endmodule

@@ rtl/pwlt_ctrl.sv @@
// Controller state machine: sequences load, clear, clamp checks, scan and division.
// Depends on pwlt_pkg.
module pwlt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  pwlt_pkg::stat_type  stat,
   output pwlt_pkg::cmd_type   cmd
);
   import pwlt_pkg::*;

   state_type state_ff, state_in;
   logic [RowBits-1:0] idx_ff, idx_in;
   logic [RowBits-1:0] last;

   assign last = RowBits'(stat.rows - 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         S_IDLE: if (req_valid) state_in = S_RD_FIRST;
         S_RD_FIRST: begin
            if (stat.command == CMD_QUERY && stat.rows != '0) begin
               state_in = S_CHK_FIRST;
            end else begin
               state_in = S_OUT;
            end
         end
         S_CHK_FIRST: state_in = stat.e_le_rd ? S_OUT : S_RD_LAST;
         S_RD_LAST:   state_in = S_CHK_LAST;
         S_CHK_LAST: begin
            if (stat.e_ge_rd) begin
               state_in = S_OUT;
            end else begin
               state_in = S_SCAN_RD;
               idx_in   = RowBits'(1);
            end
         end
         S_SCAN_RD: state_in = S_SCAN_CHK;
         S_SCAN_CHK: begin
            if (stat.e_le_rd || idx_ff == last) begin
               state_in = S_RD_LO;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_RD_LO:    state_in = S_MUL;
         S_MUL:      state_in = S_DIV_LOAD;
         S_DIV_LOAD: state_in = S_DIV;
         S_DIV:      if (stat.div_done) state_in = S_FIN;
         S_FIN:      state_in = S_OUT;
         S_OUT:      if (!rsp_stall) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = state_ff != S_IDLE;
      rsp_valid = state_ff == S_OUT;
      case (state_ff)
         S_IDLE: cmd.capture = req_valid;
         S_RD_FIRST: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = '0;
            cmd.set_result = 1'b1;
            cmd.res_zero   = 1'b1;
            case (stat.command)
               CMD_LOAD: begin
                  cmd.write_row  = 1'b1;
                  cmd.res_status = (stat.rows >= CountBits'(TableRows)) ? ST_FULL : ST_DONE;
               end
               CMD_QUERY: cmd.res_status = ST_EMPTY;
               CMD_CLEAR: begin
                  cmd.clear_rows = 1'b1;
                  cmd.res_status = ST_DONE;
               end
               default: cmd.res_status = ST_DONE;
            endcase
         end
         S_CHK_FIRST: begin
            cmd.set_result  = stat.e_le_rd;
            cmd.res_from_hi = 1'b1;
            cmd.res_status  = ST_LOW;
         end
         S_RD_LAST: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = last;
         end
         S_CHK_LAST: begin
            cmd.set_result  = stat.e_ge_rd;
            cmd.res_from_hi = 1'b1;
            cmd.res_status  = ST_HIGH;
         end
         S_SCAN_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = idx_ff;
         end
         S_SCAN_CHK: begin
            if (stat.e_le_rd || idx_ff == last) begin
               cmd.take_hi = 1'b1;
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = idx_ff - 1'b1;
            end
         end
         S_RD_LO:    cmd.take_lo = 1'b1;
         S_MUL:      cmd.mul_go = 1'b1;
         // Division starts in the cycle after the product is registered.
         S_DIV_LOAD: cmd.div_start = 1'b1;
         S_DIV:      cmd.div_step = !stat.div_done;
         S_FIN: begin
            cmd.set_result = 1'b1;
            cmd.res_status = ST_INTERP;
         end
         default: cmd = '0;
      endcase
   end
endmodule

@@ rtl/piecewise_linear_table_interp_top.sv @@
// Piecewise linear interpolation table: one transaction in, one transaction out.
// Loads, clears, other commands and queries on an empty table go straight to the
// response after the first row read; a query is then checked for a clamp at the first
// row and then at the last row. An interpolated query does a linear scan over the
// energy memory, then a 64-step restoring divider.
// One transaction is worked on at a time; the result is held while rsp_stall is high.
module piecewise_linear_table_interp_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [2:0]  req_query_quantity,
   input  logic [31:0] req_row_energy,
   input  logic [31:0] req_ion_loss,
   input  logic [31:0] req_rad_loss,
   input  logic [31:0] req_total_loss,
   input  logic [31:0] req_csda_range,
   input  logic [31:0] req_rad_yield,
   input  logic [31:0] req_density_corr,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_result_value,
   output logic [2:0]  rsp_status
);
   import pwlt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   pwlt_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .stat, .cmd
   );

   pwlt_datapath u_dp (
      .clock, .reset, .req_command, .req_query_quantity, .req_row_energy,
      .req_row_cols({req_density_corr, req_rad_yield, req_csda_range,
                     req_total_loss, req_rad_loss, req_ion_loss}),
      .cmd, .stat,
      .result_value(rsp_result_value), .result_status(rsp_status)
   );
endmodule
